[hdl/lfd_pkg.sv]
// Shared types and constants for the length-prefixed frame deframer.
`default_nettype none
package lfd_pkg;

    // Header layout, byte offsets into the little-endian header
    localparam int HEADER_BYTES   = 36;
    localparam int CNT_W          = $clog2(HEADER_BYTES);
    localparam int OFF_MAGIC      = 0;
    localparam int OFF_DATA_TYPE  = 4;
    localparam int OFF_STREAM     = 8;
    localparam int OFF_FRAME_TYPE = 12;
    localparam int OFF_SIZE       = 16;
    localparam int OFF_SEQUENCE   = 20;
    localparam int OFF_TIMESTAMP  = 28;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BUF = 1'd1;
    localparam logic [31:0] MAGIC_RESET   = 32'd0;
    localparam logic [23:0] MAX_BUF_RESET = 24'd3145728;

    // Parser phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } t_phase;

    // Result status codes
    typedef enum logic [1:0] {
        ST_BYTE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_MAGIC    = 2'd2,
        ST_OVERSIZE = 2'd3
    } t_status;

endpackage
`default_nettype wire

[hdl/length_prefixed_frame_deframer.sv]
// Top level of the length-prefixed frame deframer: header parse and payload forward.
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+-------------------------------------------
//  input    | i_valid / o_ready        | i_data_byte, i_chunk_first
//  result   | o_valid / i_ready        | o_status, o_payload_byte, o_frame_last,
//           |                          | o_data_type .. o_timestamp
//  config   | i_cfg_we (no wait)       | i_cfg_idx, i_cfg_data
//
// One byte per clock while the result register is not stalled; a result shows in the cycle after its byte is accepted.
// Latency and throughput are set by the single result register.
// Reset (synchronous, active low) clears phase, counters and result valid, and loads the config reset values.
// A stalled result register stops input transfers until it drains.
// Header fields are read straight from the header byte store, which only changes
// when the result register is free or drains in the same cycle.
`default_nettype none
module length_prefixed_frame_deframer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input channel
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_chunk_first,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [1:0]                          o_status,
    output logic [7:0]                          o_payload_byte,
    output logic                                o_frame_last,
    output logic [31:0]                         o_data_type,
    output logic [31:0]                         o_stream_type,
    output logic [31:0]                         o_frame_type,
    output logic [31:0]                         o_frame_size,
    output logic signed [63:0]                  o_sequence_res,
    output logic signed [63:0]                  o_timestamp,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [lfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [31:0]                    i_cfg_data
);
    import lfd_pkg::*;

    // Configuration registers
    logic [31:0] r_magic;
    logic [23:0] r_max_buf;

    // Parser state
    t_phase               r_phase, n_phase;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [31:0]          r_left, n_left;
    logic [7:0]           r_hdr [HEADER_BYTES];

    // Result register
    logic    r_out_valid, n_out_valid;
    t_status r_out_status, n_out_status;
    logic    [7:0] r_out_byte, n_out_byte;
    logic    r_out_last, n_out_last;

    logic             w_in_xfer;
    logic             w_hdr_byte;
    logic [CNT_W-1:0] w_eff_cnt;
    logic [31:0]      w_rx_magic;
    logic [31:0]      w_size;
    logic [32:0]      w_total;
    logic             w_bad_magic;
    logic             w_hdr_done;
    logic             w_oversize;
    logic             w_with_hdr;

    assign o_ready   = !r_out_valid || i_ready;
    assign w_in_xfer = i_valid && o_ready;

    // Byte belongs to header collection: header phase, or a chunk start ending a drop
    assign w_hdr_byte = (r_phase == PH_HEADER) ||
                        (r_phase != PH_PAYLOAD && i_chunk_first);
    assign w_eff_cnt  = (r_phase == PH_HEADER) ? r_cnt : '0;

    // Magic check on the fourth byte, size check on the last byte
    assign w_rx_magic = {i_data_byte, r_hdr[OFF_MAGIC+2], r_hdr[OFF_MAGIC+1],
                         r_hdr[OFF_MAGIC]};
    assign w_size     = {r_hdr[OFF_SIZE+3], r_hdr[OFF_SIZE+2], r_hdr[OFF_SIZE+1],
                         r_hdr[OFF_SIZE]};
    assign w_total    = 33'(HEADER_BYTES) + {1'b0, w_size};
    assign w_bad_magic = (w_eff_cnt == CNT_W'(OFF_MAGIC + 3)) && (w_rx_magic != r_magic);
    assign w_hdr_done  = (w_eff_cnt == CNT_W'(HEADER_BYTES - 1));
    assign w_oversize  = w_total > {9'd0, r_max_buf};

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (w_in_xfer) begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    if (r_left == 32'd1) n_phase = PH_HEADER;
                end
                PH_HEADER, PH_DROP: begin
                    if (w_hdr_byte) begin
                        if (w_bad_magic) begin
                            n_phase = PH_DROP;
                        end else if (w_hdr_done) begin
                            if (w_oversize)          n_phase = PH_DROP;
                            else if (w_size == '0)   n_phase = PH_HEADER;
                            else                     n_phase = PH_PAYLOAD;
                        end else begin
                            n_phase = PH_HEADER;
                        end
                    end
                end
                default: begin
                    if (i_chunk_first) n_phase = PH_HEADER;
                end
            endcase
        end
    end

    // Counters and result
    always_comb begin
        n_cnt        = r_cnt;
        n_left       = r_left;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        if (w_in_xfer) begin
            if (r_phase == PH_PAYLOAD) begin
                n_left       = r_left - 32'd1;
                n_out_valid  = 1'b1;
                n_out_status = ST_BYTE;
                n_out_byte   = i_data_byte;
                n_out_last   = (r_left == 32'd1);
                n_cnt        = '0;
            end else if (w_hdr_byte) begin
                n_cnt = w_eff_cnt + CNT_W'(1);
                if (w_bad_magic) begin
                    n_cnt        = '0;
                    n_out_valid  = 1'b1;
                    n_out_status = ST_MAGIC;
                    n_out_byte   = '0;
                    n_out_last   = 1'b0;
                end else if (w_hdr_done) begin
                    n_cnt = '0;
                    if (w_oversize) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_OVERSIZE;
                        n_out_byte   = '0;
                        n_out_last   = 1'b0;
                    end else if (w_size == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_EMPTY;
                        n_out_byte   = '0;
                        n_out_last   = 1'b1;
                    end else begin
                        n_left = w_size;
                    end
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_cnt       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            r_magic     <= MAGIC_RESET;
            r_max_buf   <= MAX_BUF_RESET;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAGIC:   r_magic   <= i_cfg_data;
                    CFG_MAX_BUF: r_max_buf <= i_cfg_data[23:0];
                    default:     ;
                endcase
            end
        end
    end

    // Result payload and header byte store
    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        if (w_in_xfer && r_phase != PH_PAYLOAD && w_hdr_byte) begin
            r_hdr[w_eff_cnt] <= i_data_byte;
        end
    end

    // Header fields go out with payload and empty-frame results, zero on errors
    assign w_with_hdr = (r_out_status == ST_BYTE) || (r_out_status == ST_EMPTY);

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_payload_byte = r_out_byte;
    assign o_frame_last   = r_out_last;
    assign o_data_type    = w_with_hdr ?
        {r_hdr[OFF_DATA_TYPE+3], r_hdr[OFF_DATA_TYPE+2],
         r_hdr[OFF_DATA_TYPE+1], r_hdr[OFF_DATA_TYPE]} : '0;
    assign o_stream_type  = w_with_hdr ?
        {r_hdr[OFF_STREAM+3], r_hdr[OFF_STREAM+2],
         r_hdr[OFF_STREAM+1], r_hdr[OFF_STREAM]} : '0;
    assign o_frame_type   = w_with_hdr ?
        {r_hdr[OFF_FRAME_TYPE+3], r_hdr[OFF_FRAME_TYPE+2],
         r_hdr[OFF_FRAME_TYPE+1], r_hdr[OFF_FRAME_TYPE]} : '0;
    assign o_frame_size   = w_with_hdr ? w_size : '0;
    assign o_sequence_res = w_with_hdr ?
        {r_hdr[OFF_SEQUENCE+7], r_hdr[OFF_SEQUENCE+6], r_hdr[OFF_SEQUENCE+5],
         r_hdr[OFF_SEQUENCE+4], r_hdr[OFF_SEQUENCE+3], r_hdr[OFF_SEQUENCE+2],
         r_hdr[OFF_SEQUENCE+1], r_hdr[OFF_SEQUENCE]} : '0;
    assign o_timestamp    = w_with_hdr ?
        {r_hdr[OFF_TIMESTAMP+7], r_hdr[OFF_TIMESTAMP+6], r_hdr[OFF_TIMESTAMP+5],
         r_hdr[OFF_TIMESTAMP+4], r_hdr[OFF_TIMESTAMP+3], r_hdr[OFF_TIMESTAMP+2],
         r_hdr[OFF_TIMESTAMP+1], r_hdr[OFF_TIMESTAMP]} : '0;

    // Checks
    a_payload_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_left != '0))
        else $error("payload phase with no bytes left");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(HEADER_BYTES))
        else $error("header count out of range");

    a_cnt_clear_outside_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HEADER) |-> (r_cnt == '0))
        else $error("header count not cleared outside header collection");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out_status)
                                        && $stable(r_out_byte)))
        else $error("stalled result overwritten");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |->
            (r_out_status == ST_BYTE || r_out_status == ST_EMPTY))
        else $error("frame_last on an error result");

endmodule
`default_nettype wire
